// ===== rtl/core/hill_cipher_block_transform_top_assert.svh =====
// assertion macros for the hill cipher block transform
`ifndef HILL_CIPHER_BLOCK_TRANSFORM_TOP_ASSERT_SVH
`define HILL_CIPHER_BLOCK_TRANSFORM_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HCBT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HCBT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCBT_ASSERT(lbl, prop, msg)
`define HCBT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/hcbt_pkg.sv =====
package hcbt_pkg;

	localparam int N_MAX      = 4;
	localparam int IDX_W      = 7;
	localparam int ACC_W      = 16;
	localparam int Q_W        = 10;
	localparam int RECIP_SH   = 22;
	localparam int ROW_W      = 28;

	localparam logic [7:0]       FIRST_CODE = 8'd32;
	localparam logic [7:0]       END_CODE   = 8'd127;
	localparam logic [ACC_W-1:0] RECIP      = 16'd44151;
	localparam logic [ACC_W-1:0] ALPHA      = 16'd95;

	localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
	localparam logic [2:0] CFG_ROW0     = 3'd1;
	localparam logic [2:0] CFG_ROW1     = 3'd2;
	localparam logic [2:0] CFG_ROW2     = 3'd3;
	localparam logic [2:0] CFG_ROW3     = 3'd4;

	localparam logic [2:0] N_LOW       = 3'd2;
	localparam logic [2:0] N_HIGH      = 3'd4;

	typedef struct packed {
		logic       buf_we;
		logic [1:0] buf_idx;
		logic       acc_mac;
		logic       acc_first;
		logic [1:0] k;
		logic [1:0] j;
		logic [2:0] blk_fill;
		logic       q_load;
		logic       out_load;
		logic       out_blast;
		logic       out_mlast;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0] n;
		logic       size_wr;
		logic       out_free;
	} dp_stat_t;

endpackage

// ===== rtl/core/hcbt_ctrl.sv =====
module hcbt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tlast,
	output logic                  s_tready,
	input  hcbt_pkg::dp_stat_t    stat,
	output hcbt_pkg::ctrl_cmd_t   cmd
);

`include "hill_cipher_block_transform_top_assert.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MAC  = 2'd1;
	localparam logic [1:0] ST_RED  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [2:0] fill_q;
	logic [2:0] blk_fill_q;
	logic [1:0] k_q;
	logic [1:0] j_q;
	logic       eom_q;

	logic       in_acc;
	logic [2:0] fill_eff;
	logic [2:0] fill_nxt;
	logic [2:0] n_m1;
	logic       row_last;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign fill_eff = (fill_q >= stat.n) ? 3'd0 : fill_q;
	assign fill_nxt = fill_eff + 3'd1;
	assign n_m1     = stat.n - 3'd1;
	assign row_last = ({1'b0, j_q} == n_m1);

	always_comb begin
		cmd.buf_we    = in_acc;
		cmd.buf_idx   = fill_eff[1:0];
		cmd.acc_mac   = (state_q == ST_MAC);
		cmd.acc_first = (k_q == 2'd0);
		cmd.k         = k_q;
		cmd.j         = j_q;
		cmd.blk_fill  = blk_fill_q;
		cmd.q_load    = (state_q == ST_RED);
		cmd.out_load  = (state_q == ST_FIN) && stat.out_free;
		cmd.out_blast = row_last;
		cmd.out_mlast = row_last && eom_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= 3'd0;
			blk_fill_q <= 3'd0;
			k_q        <= 2'd0;
			j_q        <= 2'd0;
			eom_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (stat.size_wr) begin
						fill_q <= 3'd0;
					end
					if (in_acc) begin
						if (fill_nxt >= stat.n || s_tlast) begin
							blk_fill_q <= fill_nxt;
							fill_q     <= 3'd0;
							eom_q      <= s_tlast;
							k_q        <= 2'd0;
							j_q        <= 2'd0;
							state_q    <= ST_MAC;
						end else begin
							fill_q <= fill_nxt;
						end
					end
				end
				ST_MAC: begin
					if ({1'b0, k_q} == n_m1) begin
						state_q <= ST_RED;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_RED: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (stat.out_free) begin
						k_q <= 2'd0;
						if (row_last) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + 2'd1;
							state_q <= ST_MAC;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a block in flight always holds at least the character that closed it
	`HCBT_ASSERT(a_blk_nonempty, (state_q != ST_IDLE) |-> (blk_fill_q != 3'd0), "empty block in flight")
	`HCBT_ASSERT(a_red_to_fin, (state_q == ST_RED) |=> (state_q == ST_FIN), "reduce step not followed by output step")
	`HCBT_ASSERT(a_fin_hold, (state_q == ST_FIN && !stat.out_free) |=> (state_q == ST_FIN && $stable(j_q)), "row lost while output stalled")

endmodule

// ===== rtl/core/hcbt_dp.sv =====
module hcbt_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            char_code,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [27:0]           cfg_data,
	input  hcbt_pkg::ctrl_cmd_t   cmd,
	output hcbt_pkg::dp_stat_t    stat,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [6:0]            out_char,
	output logic                  block_last,
	output logic                  message_last
);

	logic [2:0]                    key_size_q;
	logic [hcbt_pkg::ROW_W-1:0]    key_row_q [hcbt_pkg::N_MAX];
	logic [hcbt_pkg::IDX_W-1:0]    buf_q [hcbt_pkg::N_MAX];
	logic [hcbt_pkg::ACC_W-1:0]    acc_q;
	logic [hcbt_pkg::Q_W-1:0]      q_q;
	logic                          out_valid_q;
	logic [6:0]                    out_char_q;
	logic                          out_blast_q;
	logic                          out_mlast_q;

	logic                          cfg_wr;
	logic [hcbt_pkg::IDX_W-1:0]    idx;
	logic [hcbt_pkg::ROW_W-1:0]    row_sh;
	logic [hcbt_pkg::IDX_W-1:0]    key_ent;
	logic [hcbt_pkg::IDX_W-1:0]    v;
	logic [2*hcbt_pkg::IDX_W-1:0]  prod;
	logic [2*hcbt_pkg::ACC_W-1:0]  qm;
	logic [hcbt_pkg::ACC_W-1:0]    q_mul;
	logic [hcbt_pkg::ACC_W-1:0]    rem;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		if (key_size_q < hcbt_pkg::N_LOW) begin
			stat.n = hcbt_pkg::N_LOW;
		end else if (key_size_q > hcbt_pkg::N_HIGH) begin
			stat.n = hcbt_pkg::N_HIGH;
		end else begin
			stat.n = key_size_q;
		end
		stat.size_wr  = cfg_wr && (cfg_index == hcbt_pkg::CFG_KEY_SIZE);
		stat.out_free = !out_valid_q || m_tready;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= hcbt_pkg::N_LOW;
			for (int i = 0; i < hcbt_pkg::N_MAX; i++) begin
				key_row_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_index)
				hcbt_pkg::CFG_KEY_SIZE: key_size_q   <= cfg_data[2:0];
				hcbt_pkg::CFG_ROW0:     key_row_q[0] <= cfg_data;
				hcbt_pkg::CFG_ROW1:     key_row_q[1] <= cfg_data;
				hcbt_pkg::CFG_ROW2:     key_row_q[2] <= cfg_data;
				hcbt_pkg::CFG_ROW3:     key_row_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// character to index, non-printable codes become space
	always_comb begin
		if (char_code >= hcbt_pkg::FIRST_CODE && char_code < hcbt_pkg::END_CODE) begin
			idx = hcbt_pkg::IDX_W'(char_code - hcbt_pkg::FIRST_CODE);
		end else begin
			idx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.buf_we) begin
			buf_q[cmd.buf_idx] <= idx;
		end
	end

	// shared multiply-accumulate, one key entry per cycle
	assign row_sh  = key_row_q[cmd.j] >> (5'(cmd.k) * 5'd7);
	assign key_ent = row_sh[hcbt_pkg::IDX_W-1:0];
	assign v       = ({1'b0, cmd.k} < cmd.blk_fill) ? buf_q[cmd.k] : '0;
	assign prod    = key_ent * v;

	always_ff @(posedge clk) begin
		if (cmd.acc_mac) begin
			acc_q <= (cmd.acc_first ? '0 : acc_q) + hcbt_pkg::ACC_W'(prod);
		end
	end

	// mod 95 by reciprocal multiply, exact for a 16-bit sum
	assign qm = acc_q * hcbt_pkg::RECIP;

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			q_q <= qm[hcbt_pkg::RECIP_SH +: hcbt_pkg::Q_W];
		end
	end

	assign q_mul = hcbt_pkg::ACC_W'(q_q * hcbt_pkg::ALPHA);
	assign rem   = acc_q - q_mul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_char_q  <= rem[6:0] + 7'(hcbt_pkg::FIRST_CODE);
			out_blast_q <= cmd.out_blast;
			out_mlast_q <= cmd.out_mlast;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign out_char     = out_char_q;
	assign block_last   = out_blast_q;
	assign message_last = out_mlast_q;

endmodule

// ===== rtl/core/hill_cipher_block_transform_top.sv =====
// channel  dir  payload
// s_*      in   tdata[7:0] char_code, tlast end_of_message
// m_*      out  tdata[6:0] out_char, tlast block_last, tuser message_last
// cfg_*    in   cfg_index 0 key_size, 1..4 key_row0..3; cfg_data[27:0]
//
// one character is taken per cycle while a block fills
// a full block yields n outputs, each made by the shared multiply-accumulate
// over the row's key entries, one reciprocal step for mod 95, one output load
// input is held off while a block is being computed
// a stalled output freezes the sequencer; arst_n clears the block fill
module hill_cipher_block_transform_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_char, zero
	output logic        m_tlast,
	output logic        m_tuser,   // message_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [27:0] cfg_data
);

	hcbt_pkg::ctrl_cmd_t cmd;
	hcbt_pkg::dp_stat_t  stat;
	logic [6:0]          out_char;

	hcbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hcbt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (s_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.out_char     (out_char),
		.block_last   (m_tlast),
		.message_last (m_tuser)
	);

	assign m_tdata = {1'b0, out_char};

endmodule

// ===== sim/tb_hill_cipher_block_transform_top.sv =====
module tb_hill_cipher_block_transform_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CFG_SPARE_LO  = 3'd5;
	localparam logic [2:0] CFG_SPARE_MID = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI  = 3'd7;
	localparam int unsigned ALPHABET_SIZE = 95;
	localparam int DRAIN_CYCLES = 48;

	typedef struct packed {
		logic [6:0] ch;
		logic       blk_last;
		logic       msg_last;
	} cipher_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [27:0] cfg_data = 28'd0;

	// predictor state
	logic [2:0]  hill_key_size;
	logic [27:0] hill_rows [4];
	logic [6:0]  hill_block [4];
	int unsigned hill_fill;

	cipher_out_t cipher_expected [$];
	int err_count = 0;
	bit no_idle = 1'b0;

	hill_cipher_block_transform_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("tb_hill_cipher_block_transform_top: errors");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(99) >= 9);
	end

	function automatic int unsigned key_entry_of(int unsigned row, int unsigned col);
		return int'(hill_rows[row][7*col +: 7]);
	endfunction

	task automatic hill_apply_cfg(input logic [2:0] idx, input logic [27:0] data);
		if (idx == hcbt_pkg::CFG_KEY_SIZE) begin
			hill_key_size = data[2:0];
			hill_fill = 0;
		end else if (idx >= hcbt_pkg::CFG_ROW0 && idx <= hcbt_pkg::CFG_ROW3) begin
			hill_rows[idx - hcbt_pkg::CFG_ROW0] = data;
		end
	endtask

	task automatic hill_predict_char(input logic [7:0] code, input logic eom);
		int unsigned n;
		int unsigned acc;
		int unsigned v;
		cipher_out_t res;
		n = hill_key_size;
		if (n < hcbt_pkg::N_LOW) n = hcbt_pkg::N_LOW;
		if (n > hcbt_pkg::N_HIGH) n = hcbt_pkg::N_HIGH;
		if (hill_fill >= n) hill_fill = 0;
		if (code >= hcbt_pkg::FIRST_CODE && code < hcbt_pkg::END_CODE)
			hill_block[hill_fill] = 7'(code - hcbt_pkg::FIRST_CODE);
		else
			hill_block[hill_fill] = 7'd0;
		hill_fill++;
		if (hill_fill < n && !eom) return;
		for (int j = 0; j < n; j++) begin
			acc = 0;
			for (int k = 0; k < n; k++) begin
				v = (k < hill_fill) ? int'(hill_block[k]) : 0;
				acc += key_entry_of(j, k) * v;
			end
			res.ch = 7'((acc % ALPHABET_SIZE) + hcbt_pkg::FIRST_CODE);
			res.blk_last = (j == n - 1);
			res.msg_last = eom && (j == n - 1);
			cipher_expected = {cipher_expected, res};
		end
		hill_fill = 0;
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		cipher_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (cipher_expected.size() == 0) begin
				$error("result with no pending transaction: tdata=%h tlast=%b tuser=%b",
					m_tdata, m_tlast, m_tuser);
				err_count++;
			end else begin
				want = cipher_expected.pop_front();
				if (m_tdata !== {1'b0, want.ch}) begin
					$error("out_char: expected %h, actual %h", {1'b0, want.ch}, m_tdata);
					err_count++;
				end
				if (m_tlast !== want.blk_last) begin
					$error("block_last: expected %b, actual %b", want.blk_last, m_tlast);
					err_count++;
				end
				if (m_tuser !== want.msg_last) begin
					$error("message_last: expected %b, actual %b", want.msg_last, m_tuser);
					err_count++;
				end
			end
		end
	end

	task automatic send_char(input logic [7:0] code, input logic eom);
		if (!no_idle && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		s_tlast  <= eom;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		hill_predict_char(code, eom);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [27:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		hill_apply_cfg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (cipher_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [27:0] rand_row(input int mode);
		logic [27:0] r;
		case (mode)
			0: r = 28'd0;
			1: r = 28'hFFFFFFF;
			2: r = 28'($urandom);
			default: begin
				r = 28'd0;
				for (int k = 0; k < 4; k++)
					r[7*k +: 7] = 7'($urandom_range(0, 94));
			end
		endcase
		return r;
	endfunction

	task automatic test_reset_defaults;
		send_char(8'd65, 1'b0);
		send_char(8'd90, 1'b0);
		drain();
	endtask

	task automatic test_char_extremes;
		cfg_write(hcbt_pkg::CFG_KEY_SIZE, 28'(hcbt_pkg::N_LOW));
		cfg_write(hcbt_pkg::CFG_ROW0, 28'd1);
		cfg_write(hcbt_pkg::CFG_ROW1, 28'd1 << 7);
		send_char(8'd0, 1'b0);
		send_char(8'd31, 1'b0);
		send_char(8'd32, 1'b0);
		send_char(8'd126, 1'b0);
		send_char(8'd127, 1'b0);
		send_char(8'd255, 1'b0);
		drain();
		// key entries above 94
		cfg_write(hcbt_pkg::CFG_ROW0, 28'hFFFFFFF);
		cfg_write(hcbt_pkg::CFG_ROW1, 28'hFFFFFFF);
		send_char(8'd126, 1'b0);
		send_char(8'd126, 1'b1);
		drain();
	endtask

	task automatic test_key_size_clamp;
		for (int r = 0; r < 4; r++)
			cfg_write(hcbt_pkg::CFG_ROW0 + 3'(r), rand_row(3));
		cfg_write(hcbt_pkg::CFG_KEY_SIZE, 28'd0);
		send_char(8'd33, 1'b0);
		send_char(8'd125, 1'b0);
		drain();
		cfg_write(hcbt_pkg::CFG_KEY_SIZE, 28'd7);
		send_char(8'd40, 1'b0);
		send_char(8'd50, 1'b0);
		send_char(8'd60, 1'b0);
		send_char(8'd70, 1'b0);
		drain();
		cfg_write(hcbt_pkg::CFG_KEY_SIZE, 28'd1);
		send_char(8'd100, 1'b1);
		drain();
		cfg_write(hcbt_pkg::CFG_KEY_SIZE, 28'd5);
		send_char(8'd101, 1'b1);
		drain();
	endtask

	task automatic test_partial_block;
		cfg_write(hcbt_pkg::CFG_KEY_SIZE, 28'd3);
		send_char(8'd104, 1'b1);
		send_char(8'd97, 1'b0);
		send_char(8'd98, 1'b1);
		drain();
		// rewriting key_size drops the partial block
		cfg_write(hcbt_pkg::CFG_KEY_SIZE, 28'(hcbt_pkg::N_HIGH));
		send_char(8'd120, 1'b0);
		drain();
		cfg_write(hcbt_pkg::CFG_KEY_SIZE, 28'(hcbt_pkg::N_HIGH));
		send_char(8'd121, 1'b0);
		send_char(8'd122, 1'b1);
		drain();
	endtask

	task automatic test_spare_index;
		cfg_write(CFG_SPARE_LO, 28'($urandom));
		cfg_write(CFG_SPARE_HI, 28'($urandom));
		cfg_write(CFG_SPARE_MID, 28'($urandom));
		send_char(8'd77, 1'b0);
		send_char(8'd78, 1'b1);
		drain();
	endtask

	task automatic test_random_messages;
		int sent;
		int len;
		logic [7:0] code;
		logic eom;
		for (int phase = 0; phase < 8; phase++) begin
			no_idle = (phase == 3);
			if (phase == 0 || $urandom_range(99) < 80) begin
				if ($urandom_range(99) < 80)
					cfg_write(hcbt_pkg::CFG_KEY_SIZE,
						28'($urandom_range(hcbt_pkg::N_LOW, hcbt_pkg::N_HIGH)));
				else
					cfg_write(hcbt_pkg::CFG_KEY_SIZE,
						28'($urandom_range(0, 7)) | (28'($urandom) << 3));
			end
			for (int r = 0; r < 4; r++)
				if (phase == 0 || $urandom_range(99) < 70)
					cfg_write(hcbt_pkg::CFG_ROW0 + 3'(r),
						rand_row($urandom_range(0, 9) < 2 ?
							$urandom_range(0, 1) : $urandom_range(2, 3)));
			sent = 0;
			while (sent < 15) begin
				len = $urandom_range(1, 10);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(99) < 12)
						code = 8'($urandom_range(0, 255));
					else
						code = 8'($urandom_range(32, 126));
					eom = (i == len - 1) && ($urandom_range(99) < 85);
					if ($urandom_range(99) < 3)
						eom = 1'b1;
					send_char(code, eom);
					sent++;
				end
			end
			drain();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		hill_key_size = hcbt_pkg::N_LOW;
		for (int r = 0; r < 4; r++) begin
			hill_rows[r] = 28'd0;
			hill_block[r] = 7'd0;
		end
		hill_fill = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_char_extremes();
		test_key_size_clamp();
		test_partial_block();
		test_spare_index();
		test_random_messages();
		drain();
		if (err_count == 0)
			$display("tb_hill_cipher_block_transform_top: clean");
		else
			$display("tb_hill_cipher_block_transform_top: errors");
		$finish;
	end

endmodule
